FILE: rtl/ilie_pkg.sv
// ----------------------------------------------------------------------------
// ilie_pkg
// Shared types and constants for the indexed list with insert and erase.
// ----------------------------------------------------------------------------
`default_nettype none

package ilie_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned WIDTH_DEF = 32;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned IDX_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CNT_W  = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_INSERT = 3'd2,
    MODE_ERASE  = 3'd3,
    MODE_READ   = 3'd4,
    MODE_CLEAR  = 3'd5
  } mode_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_FINAL,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  index;
    logic [VAL_W-1:0]  value_in;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] value_out;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] entry_count;
  } res_t;

  typedef struct packed {
    logic accept;
    logic shift;
    logic final_wr;
  } cmd_t;

  typedef struct packed {
    logic shift_needed;
    logic final_needed;
    logic last_move;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/ilie_ram.sv
// ----------------------------------------------------------------------------
// ilie_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ilie_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/ilie_ctrl.sv
// ----------------------------------------------------------------------------
// ilie_ctrl
// Controller: sequences accept, shift, final write and the result cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ilie_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  input  wire ilie_pkg::dp_status_t dp_i,
  output ilie_pkg::cmd_t           cmd_o,
  output logic                     busy,
  output logic                     valid_o
);

  ilie_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ilie_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ilie_pkg::S_IDLE: begin
        if (start) begin
          state_d = dp_i.shift_needed ? ilie_pkg::S_SHIFT : ilie_pkg::S_RESP;
        end
      end
      ilie_pkg::S_SHIFT: begin
        if (dp_i.last_move) begin
          state_d = dp_i.final_needed ? ilie_pkg::S_FINAL : ilie_pkg::S_RESP;
        end
      end
      ilie_pkg::S_FINAL: state_d = ilie_pkg::S_RESP;
      ilie_pkg::S_RESP:  state_d = ilie_pkg::S_IDLE;
      default:           state_d = ilie_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o   = '0;
    busy    = 1'b1;
    valid_o = 1'b0;
    unique case (state_q)
      ilie_pkg::S_IDLE: begin
        busy         = 1'b0;
        cmd_o.accept = start;
      end
      ilie_pkg::S_SHIFT: cmd_o.shift    = 1'b1;
      ilie_pkg::S_FINAL: cmd_o.final_wr = 1'b1;
      ilie_pkg::S_RESP:  valid_o        = 1'b1;
      default:           busy           = 1'b1;
    endcase
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("transfer accepted but block not busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> (!valid_o && !busy))
    else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

FILE: rtl/ilie_datapath.sv
// ----------------------------------------------------------------------------
// ilie_datapath
// Datapath: entry count, decode, shift pointers and the entry RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module ilie_datapath #(
  parameter int unsigned DEPTH = ilie_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = ilie_pkg::WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ilie_pkg::req_t       req_i,
  input  wire ilie_pkg::cmd_t       cmd_i,
  output ilie_pkg::dp_status_t      dp_o,
  output ilie_pkg::res_t            res_o
);

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned IdxW  = ilie_pkg::IDX_W;
  localparam int unsigned CmpW  = (CntW > IdxW) ? CntW : IdxW;
  localparam int unsigned OutVW = ilie_pkg::VAL_W;
  localparam int unsigned OutCW = ilie_pkg::CNT_W;

  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   moves_q, moves_d;
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [WIDTH-1:0]  val_q, val_d;
  logic              dir_up_q, dir_up_d;
  logic              ins_q, ins_d;
  logic              rsel_q, rsel_d;
  ilie_pkg::status_e status_q, status_d;

  logic              we;
  logic [AddrW-1:0]  waddr, raddr;
  logic [WIDTH-1:0]  wdata, rdata;
  logic              shift_req;

  logic [CmpW-1:0]   cnt_x, idx_x;
  logic [CntW-1:0]   cnt_m1;
  logic              full, empty;

  assign cnt_x  = CmpW'(count_q);
  assign idx_x  = CmpW'(req_i.index);
  assign cnt_m1 = count_q - CntW'(1);
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);

  always_comb begin
    count_d   = count_q;
    moves_d   = moves_q;
    wr_ptr_d  = wr_ptr_q;
    rd_ptr_d  = rd_ptr_q;
    idx_d     = idx_q;
    val_d     = val_q;
    dir_up_d  = dir_up_q;
    ins_d     = ins_q;
    rsel_d    = rsel_q;
    status_d  = status_q;
    we        = 1'b0;
    waddr     = wr_ptr_q;
    wdata     = rdata;
    raddr     = rd_ptr_q;
    shift_req = 1'b0;

    if (cmd_i.accept) begin
      status_d = ilie_pkg::ST_DONE;
      rsel_d   = 1'b0;
      ins_d    = 1'b0;
      idx_d    = AddrW'(idx_x);
      val_d    = WIDTH'(req_i.value_in);
      unique case (ilie_pkg::mode_e'(req_i.mode))
        ilie_pkg::MODE_PUSH: begin
          if (full) begin
            status_d = ilie_pkg::ST_FULL;
          end else begin
            we      = 1'b1;
            waddr   = AddrW'(count_q);
            wdata   = WIDTH'(req_i.value_in);
            count_d = count_q + CntW'(1);
          end
        end
        ilie_pkg::MODE_POP: begin
          if (empty) begin
            status_d = ilie_pkg::ST_RANGE;
          end else begin
            raddr   = AddrW'(cnt_m1);
            rsel_d  = 1'b1;
            count_d = cnt_m1;
          end
        end
        ilie_pkg::MODE_INSERT: begin
          if (idx_x > cnt_x) begin
            status_d = ilie_pkg::ST_RANGE;
          end else if (full) begin
            status_d = ilie_pkg::ST_FULL;
          end else begin
            count_d = count_q + CntW'(1);
            if (idx_x == cnt_x) begin
              we    = 1'b1;
              waddr = AddrW'(idx_x);
              wdata = WIDTH'(req_i.value_in);
            end else begin
              raddr     = AddrW'(cnt_m1);
              rd_ptr_d  = AddrW'(cnt_m1) - AddrW'(1);
              wr_ptr_d  = AddrW'(count_q);
              moves_d   = CntW'(cnt_x - idx_x);
              dir_up_d  = 1'b0;
              ins_d     = 1'b1;
              shift_req = 1'b1;
            end
          end
        end
        ilie_pkg::MODE_ERASE: begin
          if (idx_x >= cnt_x) begin
            status_d = ilie_pkg::ST_RANGE;
          end else begin
            count_d = cnt_m1;
            if ((idx_x + CmpW'(1)) != cnt_x) begin
              raddr     = AddrW'(idx_x + CmpW'(1));
              rd_ptr_d  = AddrW'(idx_x + CmpW'(2));
              wr_ptr_d  = AddrW'(idx_x);
              moves_d   = CntW'(cnt_x - idx_x - CmpW'(1));
              dir_up_d  = 1'b1;
              shift_req = 1'b1;
            end
          end
        end
        ilie_pkg::MODE_READ: begin
          if (idx_x >= cnt_x) begin
            status_d = ilie_pkg::ST_RANGE;
          end else begin
            raddr  = AddrW'(idx_x);
            rsel_d = 1'b1;
          end
        end
        ilie_pkg::MODE_CLEAR: begin
          count_d = '0;
        end
        default: begin
          status_d = ilie_pkg::ST_RANGE;
        end
      endcase
    end else if (cmd_i.shift) begin
      we      = 1'b1;
      waddr   = wr_ptr_q;
      wdata   = rdata;
      raddr   = rd_ptr_q;
      moves_d = moves_q - CntW'(1);
      if (dir_up_q) begin
        wr_ptr_d = wr_ptr_q + AddrW'(1);
        rd_ptr_d = rd_ptr_q + AddrW'(1);
      end else begin
        wr_ptr_d = wr_ptr_q - AddrW'(1);
        rd_ptr_d = rd_ptr_q - AddrW'(1);
      end
    end else if (cmd_i.final_wr) begin
      we    = 1'b1;
      waddr = idx_q;
      wdata = val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      moves_q  <= '0;
      dir_up_q <= 1'b0;
      ins_q    <= 1'b0;
      rsel_q   <= 1'b0;
      status_q <= ilie_pkg::ST_DONE;
    end else begin
      count_q  <= count_d;
      moves_q  <= moves_d;
      dir_up_q <= dir_up_d;
      ins_q    <= ins_d;
      rsel_q   <= rsel_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_ptr_q <= wr_ptr_d;
    rd_ptr_q <= rd_ptr_d;
    idx_q    <= idx_d;
    val_q    <= val_d;
  end

  ilie_ram #(
    .Width(WIDTH),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign dp_o.shift_needed = shift_req;
  assign dp_o.final_needed = ins_q;
  assign dp_o.last_move    = (moves_q == CntW'(1));

  assign res_o.value_out   = rsel_q ? OutVW'(rdata) : '0;
  assign res_o.status      = status_q;
  assign res_o.entry_count = OutCW'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count beyond depth");

  a_shift_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |-> (moves_q != '0))
    else $error("shift step with no moves left");

  a_rsel_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsel_q |-> (status_q == ilie_pkg::ST_DONE))
    else $error("data returned with error status");

endmodule

`default_nettype wire

FILE: rtl/indexed_list_insert_erase.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_erase
// Position-ordered list with push, pop, insert, erase, read and clear.
// ----------------------------------------------------------------------------
// Sequence: push, pop, read, clear and errors go from accept to the result
//   strobe; insert shifts (count - index) entries up one entry per cycle, then
//   writes the new value (no shift when index equals count); erase shifts
//   (count - 1 - index) entries down. Start is taken only while busy is low.
// The result strobe lasts one cycle and cannot be stalled.
// Reset clears the count and controller; entry storage is not cleared.
`default_nettype none

module indexed_list_insert_erase #(
  parameter int unsigned DEPTH = ilie_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = ilie_pkg::WIDTH_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire ilie_pkg::req_t req_i,
  output logic                busy,
  output logic                valid_o,
  output ilie_pkg::res_t      res_o
);

  ilie_pkg::cmd_t       cmd;
  ilie_pkg::dp_status_t dp_status;

  ilie_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .dp_i   (dp_status),
    .cmd_o  (cmd),
    .busy   (busy),
    .valid_o(valid_o)
  );

  ilie_datapath #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .dp_o  (dp_status),
    .res_o (res_o)
  );

endmodule

`default_nettype wire
